FILE: hdl/lzwd_pkg.sv
// Shared constants for the LZ window decompressor.
package lzwd_pkg;

  localparam int unsigned WIN_LOG   = 14;
  localparam int unsigned WIN_DEPTH = 1 << WIN_LOG;
  localparam int unsigned MAX_RUN   = 34;
  localparam int unsigned RUN_W     = $clog2(MAX_RUN + 1);
  localparam int unsigned LW_W      = $clog2(WIN_LOG + 1);
  localparam int unsigned FIDX_W    = 5;

endpackage

FILE: hdl/lzwd_ram.sv
// Generic simple dual-port RAM with registered read.
module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lz_window_decompressor.sv
// LZSS-style decompressor top level with a 2^WIN_LOG byte history window.
// Flag and match low bytes: one per cycle, no result. Token start bytes wait for an
//   empty output register; a literal's result appears in the cycle after acceptance.
// Match: no input is taken while it is copied; each byte is a window RAM read,
//   then a write-back and output that waits for a free output register.
// Reset (and an end-of-data mark) clears control; the window is not swept, a
//   write pointer plus wrap flag makes never-written entries read zero.
module lz_window_decompressor
  import lzwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // compressed byte requests
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  // decompressed byte requests
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  typedef enum logic [2:0] {
    ST_FLAG,
    ST_TOKEN,
    ST_MATCH_LO,
    ST_COPY_RD,
    ST_COPY_WR
  } state_e;

  // parser state
  state_e              state_q, state_d;
  logic [1:0]          fcnt_q, fcnt_d;      // flag byte count within the word
  logic [31:0]         flag_q, flag_d;
  logic [FIDX_W-1:0]   fidx_q, fidx_d;
  logic [LW_W-1:0]     lw_q, lw_d;          // distance field width
  logic [7:0]          hi_q, hi_d;
  // window fill tracking: entries below wp_q are written, or all once wrapped
  logic [WIN_LOG-1:0]  wp_q, wp_d;
  logic                wrap_q, wrap_d;
  // copy engine
  logic [WIN_LOG-1:0]  off_q, off_d;        // distance minus one
  logic [RUN_W-1:0]    cnt_q, cnt_d;
  logic                eod_q, eod_d;
  logic                rd_ok_q, rd_ok_d;
  // output register
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  // window RAM ports
  logic                ram_we, ram_re;
  logic [WIN_LOG-1:0]  ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  logic                in_acc;
  logic                out_free;
  logic                flag_bit;
  logic [15:0]         match_j, match_sh, match_mask;
  logic [7:0]          copy_byte;

  assign out_free = !out_valid_q || !out_stall_i;

  // Flag and match-low bytes never produce an immediate result; a token start byte
  // (literal or match high) needs an empty output register; copies take no bytes.
  assign in_stall_o = !((state_q == ST_FLAG) || (state_q == ST_MATCH_LO) ||
                        ((state_q == ST_TOKEN) && !out_valid_q));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign flag_bit   = flag_q[fidx_q];
  assign match_j    = {hi_q, in_byte_i};
  assign match_sh   = match_j >> lw_q;
  assign match_mask = 16'((17'd1 << lw_q) - 17'd1);
  assign ram_raddr  = wp_q - off_q - WIN_LOG'(1);
  assign copy_byte  = rd_ok_q ? ram_rdata : 8'h00;

  always_comb begin
    state_d     = state_q;
    fcnt_d      = fcnt_q;
    flag_d      = flag_q;
    fidx_d      = fidx_q;
    lw_d        = lw_q;
    hi_d        = hi_q;
    wp_d        = wp_q;
    wrap_d      = wrap_q;
    off_d       = off_q;
    cnt_d       = cnt_q;
    eod_d       = eod_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = in_byte_i;

    unique case (state_q)
      ST_FLAG: begin
        if (in_acc) begin
          if (end_of_data_i) begin
            state_d = ST_FLAG;
            fcnt_d  = '0;
            flag_d  = '0;
            fidx_d  = '0;
            lw_d    = LW_W'(WIN_LOG);
            hi_d    = '0;
            wp_d    = '0;
            wrap_d  = 1'b0;
          end else begin
            flag_d = {flag_q[23:0], in_byte_i};
            if (fcnt_q == 2'd3) begin
              fidx_d  = FIDX_W'(31);
              lw_d    = LW_W'(WIN_LOG) - LW_W'(in_byte_i[1:0]);
              state_d = ST_TOKEN;
            end else begin
              fcnt_d = fcnt_q + 2'd1;
            end
          end
        end
      end

      ST_TOKEN: begin
        if (in_acc) begin
          fidx_d = fidx_q - FIDX_W'(1);
          if (end_of_data_i) begin
            // dropped token start, full restart
            state_d = ST_FLAG;
            fcnt_d  = '0;
            flag_d  = '0;
            fidx_d  = '0;
            lw_d    = LW_W'(WIN_LOG);
            hi_d    = '0;
            wp_d    = '0;
            wrap_d  = 1'b0;
          end else if (!flag_bit) begin
            // literal
            ram_we      = 1'b1;
            ram_wdata   = in_byte_i;
            wp_d        = wp_q + WIN_LOG'(1);
            wrap_d      = wrap_q || (wp_q == '1);
            out_valid_d = 1'b1;
            out_byte_d  = in_byte_i;
            out_last_d  = 1'b1;
            fcnt_d      = '0;
            state_d     = (fidx_d <= FIDX_W'(1)) ? ST_FLAG : ST_TOKEN;
          end else begin
            hi_d    = in_byte_i;
            state_d = ST_MATCH_LO;
          end
        end
      end

      ST_MATCH_LO: begin
        if (in_acc) begin
          off_d = match_j[WIN_LOG-1:0] & match_mask[WIN_LOG-1:0];
          if (match_sh > 16'(MAX_RUN - 3)) begin
            cnt_d = RUN_W'(MAX_RUN);
          end else begin
            cnt_d = match_sh[RUN_W-1:0] + RUN_W'(3);
          end
          eod_d   = end_of_data_i;
          state_d = ST_COPY_RD;
        end
      end

      ST_COPY_RD: begin
        ram_re  = 1'b1;
        rd_ok_d = wrap_q || (ram_raddr < wp_q);
        state_d = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        if (out_free) begin
          ram_we      = 1'b1;
          ram_wdata   = copy_byte;
          wp_d        = wp_q + WIN_LOG'(1);
          wrap_d      = wrap_q || (wp_q == '1);
          out_valid_d = 1'b1;
          out_byte_d  = copy_byte;
          out_last_d  = (cnt_q == RUN_W'(1));
          cnt_d       = cnt_q - RUN_W'(1);
          if (cnt_q == RUN_W'(1)) begin
            fcnt_d = '0;
            if (eod_q) begin
              state_d = ST_FLAG;
              flag_d  = '0;
              fidx_d  = '0;
              lw_d    = LW_W'(WIN_LOG);
              hi_d    = '0;
              wp_d    = '0;
              wrap_d  = 1'b0;
            end else begin
              state_d = (fidx_q <= FIDX_W'(1)) ? ST_FLAG : ST_TOKEN;
            end
          end else begin
            state_d = ST_COPY_RD;
          end
        end
      end

      default: state_d = ST_FLAG;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FLAG;
      fcnt_q      <= '0;
      flag_q      <= '0;
      fidx_q      <= '0;
      lw_q        <= LW_W'(WIN_LOG);
      hi_q        <= '0;
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      off_q       <= '0;
      cnt_q       <= '0;
      eod_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcnt_q      <= fcnt_d;
      flag_q      <= flag_d;
      fidx_q      <= fidx_d;
      lw_q        <= lw_d;
      hi_q        <= hi_d;
      wp_q        <= wp_d;
      wrap_q      <= wrap_d;
      off_q       <= off_d;
      cnt_q       <= cnt_d;
      eod_q       <= eod_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

`ifndef SYNTHESIS
  // the copy engine never runs with an empty count
  a_copy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY_WR || state_q == ST_COPY_RD) |-> cnt_q != '0)
    else $error("copy engine active with zero count");

  // read and write of the window never share a cycle
  a_ram_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("window read and write in the same cycle");

  // a dropped end-of-data byte empties the window
  a_eod_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_data_i && (state_q == ST_FLAG || state_q == ST_TOKEN))
    |=> (wp_q == '0) && !wrap_q && (state_q == ST_FLAG))
    else $error("end-of-data did not restart the window");

  // a literal shows up as a single-byte run on the next cycle
  a_literal_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q == ST_TOKEN && !flag_bit && !end_of_data_i)
    |=> out_valid_o && run_last_o)
    else $error("literal not presented at the output");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for lz_window_decompressor: streams compressed requests, checks every output byte.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzwd_pkg::*;

  localparam int RANDOM_REQS    = 155;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 100;   // longest match is 34 bytes
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving on either side
  localparam int MAX_REPORTS    = 10;

  // Parser position inside the compressed stream
  typedef enum logic [2:0] {
    PH_FLAG0, PH_FLAG1, PH_FLAG2, PH_FLAG3, PH_TOKEN, PH_MATCH_LO
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } comp_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i     = '0;
  logic       end_of_data_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  lz_window_decompressor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stimulus and expected output
  comp_req_t     payload_q[$];
  decoded_byte_t decoded_q[$];

  // Traffic shaping, changed only at falling edges
  bit stim_en       = 1'b0;
  bit send_pause    = 1'b0;
  bit recv_hold     = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int accepted_cnt = 0;
  int error_cnt    = 0;
  int stuck_cycles = 0;

  // Decoder shadow state
  logic [7:0]        hist_mem [WIN_DEPTH];
  logic [WIN_LOG-1:0] wr_ptr;
  logic [31:0]       flags;
  logic [FIDX_W-1:0] flag_pos;
  logic [LW_W-1:0]   len_bits;
  parse_phase_e      phase;
  logic [7:0]        hi_byte;

  task automatic clear_decoder();
    for (int i = 0; i < WIN_DEPTH; i++) hist_mem[i] = 8'h00;
    wr_ptr   = '0;
    flags    = '0;
    flag_pos = '0;
    len_bits = LW_W'(WIN_LOG);
    phase    = PH_FLAG0;
    hi_byte  = '0;
  endtask

  // Appends one predicted output byte.
  task automatic expect_byte(input logic [7:0] d, input logic l);
    decoded_byte_t item;
    item.data = d;
    item.last = l;
    decoded_q.insert(decoded_q.size(), item);
  endtask

  // Runs one accepted request through the shadow decoder and queues the bytes it yields.
  task automatic decode_request(input logic [7:0] b, input logic eod);
    logic [15:0] tok;
    logic [7:0]  c;
    logic        flag;
    int unsigned run_len;
    int unsigned back_dist;
    int unsigned rd;
    int unsigned k;
    if (phase != PH_TOKEN && phase != PH_MATCH_LO) begin
      // flag word bytes, big-endian; an end mark here drops the byte and clears the decoder
      if (eod) begin
        clear_decoder();
      end else begin
        flags = {flags[23:0], b};
        if (phase == PH_FLAG3) begin
          flag_pos = FIDX_W'(31);
          len_bits = LW_W'(WIN_LOG - flags[1:0]);
          phase    = PH_TOKEN;
        end else begin
          phase = parse_phase_e'(phase + 1);
        end
      end
    end else if (phase == PH_TOKEN) begin
      flag     = flags[flag_pos];
      flag_pos = flag_pos - 1'b1;
      if (eod) begin
        // end mark on a token start drops the literal or the match high byte
        clear_decoder();
      end else if (!flag) begin
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        expect_byte(b, 1'b1);
        phase = (flag_pos <= 1) ? PH_FLAG0 : PH_TOKEN;
      end else begin
        hi_byte = b;
        phase   = PH_MATCH_LO;
      end
    end else begin
      tok     = {hi_byte, b};
      run_len = (tok >> len_bits) + 3;
      if (run_len > MAX_RUN) run_len = MAX_RUN;
      back_dist = (tok & ((1 << len_bits) - 1)) + 1;
      // far distances wrap the window and pick up the cleared entries
      for (k = 0; k < run_len; k++) begin
        rd = (wr_ptr - back_dist) & (WIN_DEPTH - 1);
        c  = hist_mem[rd];
        hist_mem[wr_ptr] = c;
        wr_ptr = wr_ptr + 1'b1;
        expect_byte(c, k + 1 == run_len);
      end
      if (eod) clear_decoder();
      else phase = (flag_pos <= 1) ? PH_FLAG0 : PH_TOKEN;
    end
  endtask

  task automatic add_request(input logic [7:0] b, input logic eod);
    comp_req_t item;
    item.data = b;
    item.eod  = eod;
    payload_q.insert(payload_q.size(), item);
  endtask

  task automatic report_error(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Driver: holds a stalled request, otherwise offers the next one or idles at random.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      decode_request(in_byte_i, end_of_data_i);
      void'(payload_q.pop_front());
      accepted_cnt <= accepted_cnt + 1;
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (stim_en && !send_pause && payload_q.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i    <= 1'b1;
        in_byte_i     <= payload_q[0].data;
        end_of_data_i <= payload_q[0].eod;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each output request against the oldest predicted byte.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_error($sformatf("unexpected output: byte %02h last %0b",
                               out_byte_o, run_last_o));
      end else begin
        if (out_byte_o !== decoded_q[0].data || run_last_o !== decoded_q[0].last)
          report_error($sformatf("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 decoded_q[0].data, decoded_q[0].last,
                                 out_byte_o, run_last_o));
        void'(decoded_q.pop_front());
      end
    end
    out_stall_i <= recv_hold || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog on cycles where no request moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the block backs up
  initial begin
    while (accepted_cnt < 60) @(posedge clk_i);
    @(negedge clk_i);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin
    logic [31:0] fw;
    logic [15:0] tok;
    int          lw;
    int          lenf;
    int          distf;
    int          bp;
    int          n;
    int          total;
    bit          frame_done;
    bit          end_here;

    clear_decoder();

    // Directed: flag word 0x38000003 -> lit, lit, match, match, match; 11-bit distance field
    add_request(8'h38, 1'b0);
    add_request(8'h00, 1'b0);
    add_request(8'h00, 1'b0);
    add_request(8'h03, 1'b0);
    add_request(8'h00, 1'b0);                              // literal low extreme
    add_request(8'hFF, 1'b0);                              // literal high extreme
    add_request(8'h00, 1'b0); add_request(8'h00, 1'b0);    // shortest run, distance one
    add_request(8'hFF, 1'b0); add_request(8'hFF, 1'b0);    // longest run from unwritten window
    add_request(8'h08, 1'b0); add_request(8'h24, 1'b1);    // end mark on match low byte
    // end mark on a flag byte
    add_request(8'hA5, 1'b0); add_request(8'h5A, 1'b1);
    // all literals, full-width distance field, then end mark drops a literal
    add_request(8'h00, 1'b0); add_request(8'h00, 1'b0);
    add_request(8'h00, 1'b0); add_request(8'h00, 1'b0);
    add_request(8'h7E, 1'b0);
    add_request(8'h81, 1'b1);
    // first token a match, end mark drops its high byte
    add_request(8'h80, 1'b0); add_request(8'h00, 1'b0);
    add_request(8'h00, 1'b0); add_request(8'h01, 1'b0);
    add_request(8'hC3, 1'b1);

    // Random: mostly well-formed frames with random content, some noise bursts
    total = payload_q.size() + RANDOM_REQS;
    while (payload_q.size() < total) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise, then an end mark to get back to a known parser state
        n = $urandom_range(1, 5);
        repeat (n) add_request(8'($urandom), $urandom_range(0, 3) == 0);
        add_request(8'($urandom), 1'b1);
      end else begin
        frame_done = 1'b0;
        while (!frame_done && payload_q.size() < total) begin
          fw = $urandom;
          lw = WIN_LOG - fw[1:0];
          add_request(fw[31:24], 1'b0);
          add_request(fw[23:16], 1'b0);
          add_request(fw[15:8], 1'b0);
          add_request(fw[7:0], 1'b0);
          for (bp = 31; bp >= 2 && !frame_done && payload_q.size() < total; bp--) begin
            end_here = ($urandom_range(0, 59) == 0);
            if (!fw[bp]) begin
              add_request(8'($urandom), end_here);
            end else begin
              lenf = $urandom_range(0, (1 << (16 - lw)) - 1);
              // short distances mostly, so runs copy recently written bytes
              if ($urandom_range(0, 3) != 0) distf = $urandom_range(0, 15);
              else distf = $urandom_range(0, (1 << lw) - 1);
              tok = 16'((lenf << lw) | distf);
              if (end_here && $urandom_range(0, 1) == 0) begin
                add_request(tok[15:8], 1'b1);
              end else begin
                add_request(tok[15:8], 1'b0);
                add_request(tok[7:0], end_here);
              end
            end
            frame_done = end_here;
          end
        end
      end
    end
    total = payload_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni        = 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 73;
    stim_en       = 1'b1;

    while (accepted_cnt < total / 3) @(posedge clk_i);
    @(negedge clk_i);
    send_idle_pct = 73;
    recv_idle_pct = 38;

    while (accepted_cnt < (2 * total) / 3) @(posedge clk_i);
    // sender holds until every predicted byte has come out
    @(negedge clk_i);
    send_pause = 1'b1;
    while (decoded_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_pause    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (payload_q.size() != 0) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && decoded_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lzwd_pkg.sv
hdl/lzwd_ram.sv
hdl/lz_window_decompressor.sv
test/tb_top.sv
